// ===== rtl/dfr_pkg.sv =====
// shared constants and types for the delimited frame receiver
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dfr_pkg;

  typedef logic [7:0] byte_t;

  localparam int STORE_DEPTH_DEF = 32;

  localparam logic OP_LINE    = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam int CFG_AW = 3;

  localparam logic REG_START_CHAR = 1'b0;
  localparam logic REG_END_CHAR   = 1'b1;

  localparam byte_t START_CHAR_RST = 8'd0;
  localparam byte_t END_CHAR_RST   = 8'd35;

endpackage

`default_nettype wire

// ===== rtl/dfr_in_if.sv =====
// input request channel of the delimited frame receiver
// depends on dfr_pkg
`timescale 1ns / 1ps
`default_nettype none

interface dfr_in_if
  import dfr_pkg::*;
();
  logic  valid;
  logic  ready;
  logic  op;
  byte_t line_byte;

  modport source (output valid, output op, output line_byte, input ready);
  modport sink   (input valid, input op, input line_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/dfr_out_if.sv =====
// result request channel of the delimited frame receiver
// depends on dfr_pkg
`timescale 1ns / 1ps
`default_nettype none

interface dfr_out_if
  import dfr_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t frame_byte;
  logic  last;
  logic  overflowed;

  modport source (output valid, output frame_byte, output last, output overflowed,
                  input ready);
  modport sink   (input valid, input frame_byte, input last, input overflowed,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/dfr_front.sv =====
// front end: accepts requests, tracks frame state, writes the store, queues drains
// depends on dfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module dfr_front
  import dfr_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int AW          = $clog2(STORE_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_op,
  input  wire byte_t         in_line_byte,
  input  wire byte_t         start_char,
  input  wire byte_t         end_char,
  input  wire logic          busy,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output byte_t              wr_data,
  output logic               push,
  output logic [AW:0]        push_cmd
);

  localparam logic [AW-1:0] FULL_IDX = AW'(STORE_DEPTH - 1);

  logic [AW-1:0] fill_r, fill_nxt;
  logic          in_frame_r, in_frame_nxt;
  logic          held_r, held_nxt;
  logic          acc;
  logic [AW-1:0] cmd_idx;
  logic          cmd_ovf;

  assign in_ready = !busy || held_r;
  assign acc      = in_valid && in_ready;
  assign push_cmd = {cmd_ovf, cmd_idx};

  always_comb begin
    fill_nxt     = fill_r;
    in_frame_nxt = in_frame_r;
    held_nxt     = held_r;
    wr_en        = 1'b0;
    wr_addr      = fill_r;
    wr_data      = in_line_byte;
    push         = 1'b0;
    cmd_idx      = fill_r;
    cmd_ovf      = 1'b0;
    if (acc) begin
      if (in_op == OP_RELEASE) begin
        held_nxt = 1'b0;
      end else if (!held_r) begin
        if (fill_r >= FULL_IDX) begin
          wr_en        = 1'b1;
          wr_addr      = FULL_IDX;
          wr_data      = end_char;
          push         = 1'b1;
          cmd_idx      = FULL_IDX;
          cmd_ovf      = 1'b1;
          held_nxt     = 1'b1;
          fill_nxt     = '0;
          in_frame_nxt = 1'b0;
        end else if (in_line_byte == start_char) begin
          wr_en        = 1'b1;
          wr_addr      = '0;
          fill_nxt     = AW'(1);
          in_frame_nxt = 1'b1;
        end else if (in_line_byte == end_char) begin
          wr_en        = 1'b1;
          wr_data      = end_char;
          push         = 1'b1;
          held_nxt     = 1'b1;
          fill_nxt     = '0;
          in_frame_nxt = 1'b0;
        end else if (in_frame_r) begin
          wr_en    = 1'b1;
          fill_nxt = fill_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      in_frame_r <= 1'b0;
      held_r     <= 1'b0;
    end else begin
      fill_r     <= fill_nxt;
      in_frame_r <= in_frame_nxt;
      held_r     <= held_nxt;
    end
  end

  // a closed frame is always held until released
  a_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> held_r)
    else $error("frame closed without being held");

endmodule

`default_nettype wire

// ===== rtl/dfr_cmd_fifo.sv =====
// two-entry queue of drain commands between front and back end
// depends on dfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module dfr_cmd_fifo
  import dfr_pkg::*;
#(
  parameter int W = $clog2(STORE_DEPTH_DEF) + 1
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output logic              not_empty,
  output logic [W-1:0]      pop_data
);

  logic [W-1:0] slot_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   cnt_r;

  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && cnt_r == 2'd2 && !pop))
    else $error("drain queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("drain queue underflow");

endmodule

`default_nettype wire

// ===== rtl/dfr_back.sv =====
// back end: frame store and drain sequencer that emits the held frame
// depends on dfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module dfr_back
  import dfr_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int AW          = $clog2(STORE_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire byte_t         wr_data,
  input  wire logic          cmd_valid,
  input  wire logic [AW:0]   cmd_data,
  output logic               cmd_pop,
  output logic               busy,
  output logic               out_valid,
  input  wire logic          out_ready,
  output byte_t              out_frame_byte,
  output logic               out_last,
  output logic               out_overflowed
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_OUT
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [AW-1:0] last_idx_r, last_idx_nxt;
  logic          ovf_r, ovf_nxt;
  byte_t         store_r [STORE_DEPTH];
  byte_t         rdata_r;
  logic          rd_en;

  assign rd_en          = (state_r == S_RD);
  assign cmd_pop        = (state_r == S_IDLE) && cmd_valid;
  assign busy           = (state_r != S_IDLE);
  assign out_valid      = (state_r == S_OUT);
  assign out_frame_byte = rdata_r;
  assign out_last       = (ptr_r == last_idx_r);
  assign out_overflowed = ovf_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= store_r[ptr_r];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    ptr_nxt      = ptr_r;
    last_idx_nxt = last_idx_r;
    ovf_nxt      = ovf_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          ptr_nxt      = '0;
          last_idx_nxt = cmd_data[AW-1:0];
          ovf_nxt      = cmd_data[AW];
          state_nxt    = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (out_last) begin
            state_nxt = S_IDLE;
          end else begin
            ptr_nxt   = ptr_r + AW'(1);
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ptr_r      <= '0;
      last_idx_r <= '0;
      ovf_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ptr_r      <= ptr_nxt;
      last_idx_r <= last_idx_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  // the final byte ends the drain
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> state_r == S_IDLE)
    else $error("drain continued past last byte");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> ptr_r <= last_idx_r)
    else $error("read pointer ran past frame end");

endmodule

`default_nettype wire

// ===== rtl/delimited_frame_receiver_core.sv =====
// Delimited frame receiver. Line bytes and release requests enter on in_ch, one a cycle
// while in_ch.ready is high. A frame opens on start_char and closes on end_char, or is forced
// closed with overflowed set when the store is one short of full. The closed frame is then
// emitted on out_ch: the drain command is fetched, then each byte takes a store read and then
// the output register, and the next byte is read only after out_ch has taken the current one.
// While a frame is held, requests keep being taken; after a release, in_ch
// stalls until the drain of the previous frame has finished. No clearing pass after reset.
// depends on dfr_pkg, dfr_in_if, dfr_out_if, dfr_front, dfr_cmd_fifo, dfr_back
`timescale 1ns / 1ps
`default_nettype none

module delimited_frame_receiver_core
  import dfr_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  dfr_in_if.sink                 in_ch,
  dfr_out_if.source              out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int AW = $clog2(STORE_DEPTH);

  byte_t         start_char_r;
  byte_t         end_char_r;
  logic          cfg_we;
  logic          busy;
  logic          back_busy;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  byte_t         wr_data;
  logic          push;
  logic [AW:0]   push_cmd;
  logic          cmd_valid;
  logic [AW:0]   cmd_data;
  logic          cmd_pop;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_char_r <= START_CHAR_RST;
      end_char_r   <= END_CHAR_RST;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_START_CHAR: start_char_r <= pwdata[7:0];
        REG_END_CHAR:   end_char_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_START_CHAR: prdata = {24'd0, start_char_r};
      REG_END_CHAR:   prdata = {24'd0, end_char_r};
      default:        prdata = '0;
    endcase
  end

  assign busy = cmd_valid || back_busy;

  dfr_front #(
    .STORE_DEPTH (STORE_DEPTH),
    .AW          (AW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_op        (in_ch.op),
    .in_line_byte (in_ch.line_byte),
    .start_char   (start_char_r),
    .end_char     (end_char_r),
    .busy         (busy),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  dfr_cmd_fifo #(
    .W (AW + 1)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .pop       (cmd_pop),
    .not_empty (cmd_valid),
    .pop_data  (cmd_data)
  );

  dfr_back #(
    .STORE_DEPTH (STORE_DEPTH),
    .AW          (AW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .cmd_valid      (cmd_valid),
    .cmd_data       (cmd_data),
    .cmd_pop        (cmd_pop),
    .busy           (back_busy),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_frame_byte (out_ch.frame_byte),
    .out_last       (out_ch.last),
    .out_overflowed (out_ch.overflowed)
  );

endmodule

`default_nettype wire
